// File: design/bmpdec_pkg.sv
// Shared types and constants of the BMP 24 bpp stream decoder.
package bmpdec_pkg;

	// Default image size limits
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Depth of the command queue between parser and pixel assembler
	localparam int CMD_DEPTH = 4;

	// Header layout
	localparam logic [7:0]  MAGIC_B    = 8'h42;
	localparam logic [7:0]  MAGIC_M    = 8'h4D;
	localparam logic [15:0] BPP_24     = 16'd24;
	localparam logic [31:0] HDR_LEN    = 32'd54;
	localparam logic [31:0] HDR_LAST   = 32'd53;
	localparam int          POS_OFFSET = 10;
	localparam int          POS_WIDTH  = 18;
	localparam int          POS_HEIGHT = 22;
	localparam int          POS_BPP    = 28;

	// Result kinds
	localparam logic EV_PIXEL = 1'b0;
	localparam logic EV_ERROR = 1'b1;

	// Error codes
	localparam logic [1:0] ERR_MAGIC  = 2'd0;
	localparam logic [1:0] ERR_BPP    = 2'd1;
	localparam logic [1:0] ERR_SIZE   = 2'd2;
	localparam logic [1:0] ERR_OFFSET = 2'd3;

	// Command from parser to pixel assembler
	typedef enum logic [1:0] {
		CMD_BLUE,
		CMD_GREEN,
		CMD_PIXEL,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic [11:0] column;
		logic [11:0] row;
		logic        last_pixel;
		logic [1:0]  error_code;
		logic [12:0] image_width;
		logic [12:0] image_height;
	} cmd_t;

endpackage

// File: design/bmpdec_parser.sv
// Front end: header parse, offset skip and pixel byte classification.
module bmpdec_parser #(
	parameter int MAX_WIDTH  = bmpdec_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bmpdec_pkg::DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        file_byte,
	input  logic              start_of_file,
	output logic              cmd_valid,
	output bmpdec_pkg::cmd_t  cmd
);
	import bmpdec_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_DONE,
		PH_FAILED
	} phase_t;

	phase_t        phase_q, phase_n;
	logic [31:0]   pos_q, pos_n;
	logic [31:0]   off_q, off_n;
	logic [31:0]   wid_q, wid_n;
	logic [31:0]   hgt_q, hgt_n;
	logic [15:0]   bpp_q, bpp_n;
	logic          magic_bad_q, magic_bad_n;
	logic [CW-1:0] col_q, col_n;
	logic [RW-1:0] srow_q, srow_n;
	logic [1:0]    sub_q, sub_n;
	logic          in_pad_q, in_pad_n;
	logic [1:0]    pad_cnt_q, pad_cnt_n;

	// Next state and command for the accepted beat
	always_comb begin
		logic [31:0]   p;
		logic [CW-1:0] col_inc;
		logic [RW-1:0] srow_inc;
		logic          row_end;
		p         = '0;
		col_inc   = col_q + CW'(1);
		srow_inc  = srow_q + RW'(1);
		row_end   = 1'b0;
		phase_n   = phase_q;
		pos_n     = pos_q;
		off_n     = off_q;
		wid_n     = wid_q;
		hgt_n     = hgt_q;
		bpp_n     = bpp_q;
		magic_bad_n = magic_bad_q;
		col_n     = col_q;
		srow_n    = srow_q;
		sub_n     = sub_q;
		in_pad_n  = in_pad_q;
		pad_cnt_n = pad_cnt_q;
		cmd_valid = 1'b0;
		cmd       = '0;
		if (accept) begin
			// restart on a start mark, then treat the beat as byte 0
			if (start_of_file) begin
				phase_n     = PH_HEADER;
				pos_n       = '0;
				off_n       = '0;
				wid_n       = '0;
				hgt_n       = '0;
				bpp_n       = '0;
				magic_bad_n = 1'b0;
				col_n       = '0;
				srow_n      = '0;
				sub_n       = '0;
				in_pad_n    = 1'b0;
				pad_cnt_n   = '0;
			end
			case (phase_n)
				PH_HEADER: begin
					p = pos_n;
					// capture little-endian header fields
					for (int i = 0; i < 4; i++) begin
						if (p == 32'(POS_OFFSET + i)) off_n[8*i +: 8] = file_byte;
						if (p == 32'(POS_WIDTH + i))  wid_n[8*i +: 8] = file_byte;
						if (p == 32'(POS_HEIGHT + i)) hgt_n[8*i +: 8] = file_byte;
					end
					for (int i = 0; i < 2; i++) begin
						if (p == 32'(POS_BPP + i)) bpp_n[8*i +: 8] = file_byte;
					end
					pos_n = p + 32'd1;
					if (p == 32'd0 && file_byte != MAGIC_B) magic_bad_n = 1'b1;
					if (p == 32'd1 && (magic_bad_n || file_byte != MAGIC_M)) begin
						phase_n        = PH_FAILED;
						cmd_valid      = 1'b1;
						cmd.kind       = CMD_ERROR;
						cmd.error_code = ERR_MAGIC;
					end
					// validate the header on its last byte
					if (p == HDR_LAST) begin
						magic_bad_n = 1'b0;
						if (bpp_n != BPP_24) begin
							phase_n        = PH_FAILED;
							cmd_valid      = 1'b1;
							cmd.kind       = CMD_ERROR;
							cmd.error_code = ERR_BPP;
						end else if (wid_n > 32'(MAX_WIDTH) || hgt_n > 32'(MAX_HEIGHT)) begin
							phase_n        = PH_FAILED;
							cmd_valid      = 1'b1;
							cmd.kind       = CMD_ERROR;
							cmd.error_code = ERR_SIZE;
						end else if (off_n < HDR_LEN) begin
							phase_n        = PH_FAILED;
							cmd_valid      = 1'b1;
							cmd.kind       = CMD_ERROR;
							cmd.error_code = ERR_OFFSET;
						end else if (off_n == HDR_LEN) begin
							phase_n = (wid_n == '0 || hgt_n == '0) ? PH_DONE : PH_PIXELS;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					// drop bytes up to the pixel data offset
					pos_n = pos_q + 32'd1;
					if (pos_n >= off_q) begin
						phase_n = (wid_q == '0 || hgt_q == '0) ? PH_DONE : PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (in_pad_q) begin
						// drop row padding, width mod 4 bytes
						if (pad_cnt_q + 2'd1 == wid_q[1:0]) row_end = 1'b1;
						else pad_cnt_n = pad_cnt_q + 2'd1;
					end else begin
						cmd_valid = 1'b1;
						cmd.data  = file_byte;
						case (sub_q)
							2'd0: cmd.kind = CMD_BLUE;
							2'd1: cmd.kind = CMD_GREEN;
							default: begin
								cmd.kind       = CMD_PIXEL;
								cmd.column     = 12'(col_q);
								cmd.row        = 12'(hgt_q[RW-1:0] - RW'(1) - srow_q);
								cmd.last_pixel = (col_inc == wid_q[CW-1:0]) &&
									(srow_inc == hgt_q[RW-1:0]);
							end
						endcase
						sub_n = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
						if (sub_q == 2'd2) begin
							if (col_inc == wid_q[CW-1:0]) begin
								if (wid_q[1:0] == 2'd0) begin
									row_end = 1'b1;
								end else begin
									in_pad_n  = 1'b1;
									pad_cnt_n = '0;
								end
							end else begin
								col_n = col_inc;
							end
						end
					end
					// advance to the next stored row
					if (row_end) begin
						col_n    = '0;
						sub_n    = '0;
						in_pad_n = 1'b0;
						srow_n   = srow_inc;
						if (srow_inc == hgt_q[RW-1:0]) phase_n = PH_DONE;
					end
				end
				default: begin
				end
			endcase
			cmd.image_width  = 13'(wid_n);
			cmd.image_height = 13'(hgt_n);
		end
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			off_q       <= '0;
			wid_q       <= '0;
			hgt_q       <= '0;
			bpp_q       <= '0;
			magic_bad_q <= 1'b0;
			col_q       <= '0;
			srow_q      <= '0;
			sub_q       <= '0;
			in_pad_q    <= 1'b0;
			pad_cnt_q   <= '0;
		end else begin
			phase_q     <= phase_n;
			pos_q       <= pos_n;
			off_q       <= off_n;
			wid_q       <= wid_n;
			hgt_q       <= hgt_n;
			bpp_q       <= bpp_n;
			magic_bad_q <= magic_bad_n;
			col_q       <= col_n;
			srow_q      <= srow_n;
			sub_q       <= sub_n;
			in_pad_q    <= in_pad_n;
			pad_cnt_q   <= pad_cnt_n;
		end
	end

	// A failed file stays failed until a start mark
	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FAILED && !(accept && start_of_file)) |=> phase_q == PH_FAILED)
		else $error("parser left failed phase without a start mark");

	// Padding is only counted while decoding pixels
	a_pad_in_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		in_pad_q |-> phase_q == PH_PIXELS)
		else $error("padding state outside pixel phase");

endmodule

// File: design/bmpdec_cmd_fifo.sv
// Short command queue between the parser and the pixel assembler.
module bmpdec_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  bmpdec_pkg::cmd_t  wr_data,
	output logic              full,
	input  logic              rd_en,
	output bmpdec_pkg::cmd_t  rd_data,
	output logic              not_empty
);
	import bmpdec_pkg::*;

	localparam int PW = $clog2(CMD_DEPTH);

	cmd_t          mem [CMD_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(CMD_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem[rd_ptr_q];

	// Write storage
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_ptr_q] <= wr_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + PW'(1);
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && !not_empty))
		else $error("command queue read while empty");

endmodule

// File: design/bmpdec_back.sv
// Back end: gathers B,G,R beats into pixels and holds the result register.
module bmpdec_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  bmpdec_pkg::cmd_t  cmd,
	output logic              cmd_take,
	input  logic              pop,
	output logic              empty,
	output logic              event_kind,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic [11:0]       column,
	output logic [11:0]       row,
	output logic              last_pixel,
	output logic [1:0]        error_code,
	output logic [12:0]       image_width,
	output logic [12:0]       image_height
);
	import bmpdec_pkg::*;

	logic       out_valid_q;
	logic       out_pop;
	logic       emit;
	logic [7:0] held_blue_q;
	logic [7:0] held_green_q;

	assign out_pop  = pop && out_valid_q;
	assign emit     = cmd.kind inside {CMD_PIXEL, CMD_ERROR};
	// color beats never stall; results wait for a free slot
	assign cmd_take = cmd_valid && (!emit || !out_valid_q || out_pop);
	assign empty    = !out_valid_q;

	// Track result slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_take && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold color bytes and load the result register
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			case (cmd.kind)
				CMD_BLUE:  held_blue_q  <= cmd.data;
				CMD_GREEN: held_green_q <= cmd.data;
				CMD_PIXEL: begin
					event_kind   <= EV_PIXEL;
					red          <= cmd.data;
					green        <= held_green_q;
					blue         <= held_blue_q;
					column       <= cmd.column;
					row          <= cmd.row;
					last_pixel   <= cmd.last_pixel;
					error_code   <= '0;
					image_width  <= cmd.image_width;
					image_height <= cmd.image_height;
				end
				default: begin
					event_kind   <= EV_ERROR;
					red          <= '0;
					green        <= '0;
					blue         <= '0;
					column       <= '0;
					row          <= '0;
					last_pixel   <= 1'b0;
					error_code   <= cmd.error_code;
					image_width  <= cmd.image_width;
					image_height <= cmd.image_height;
				end
			endcase
		end
	end

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> out_valid_q)
		else $error("waiting result dropped");

endmodule

// File: design/bmp24_stream_decoder.sv
// Top level of the streaming 24 bpp BMP decoder.
// Takes one file byte per beat and returns one result per pixel (RGB with its column and
// top-down row) or a single error result per file. The block accepts a byte every cycle:
// the parser updates its position and pixel counters once per byte, and a four-entry
// command queue plus a one-entry result register decouple it from the consumer, so input
// stalls only when that queue fills while results are not being popped. With the queue
// and the result register free, an accepted red byte completes a pixel that is written
// to the queue entry and then the result register. Header values are captured from the
// 54-byte header; only 24 bpp images within MAX_WIDTH by MAX_HEIGHT are decoded, and row
// padding and bytes after the image are dropped. No frame buffer and no memory clear.
module bmp24_stream_decoder #(
	parameter int MAX_WIDTH  = bmpdec_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bmpdec_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  file_byte,
	input  logic        start_of_file,
	output logic        empty,
	input  logic        pop,
	output logic        event_kind,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [11:0] column,
	output logic [11:0] row,
	output logic        last_pixel,
	output logic [1:0]  error_code,
	output logic [12:0] image_width,
	output logic [12:0] image_height
);
	import bmpdec_pkg::*;

	logic accept;
	logic cmd_valid;
	cmd_t cmd;
	logic q_valid;
	cmd_t q_cmd;
	logic q_take;

	assign accept = push && !full;

	bmpdec_parser #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.file_byte     (file_byte),
		.start_of_file (start_of_file),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd)
	);

	bmpdec_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cmd_valid),
		.wr_data   (cmd),
		.full      (full),
		.rd_en     (q_take),
		.rd_data   (q_cmd),
		.not_empty (q_valid)
	);

	bmpdec_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd          (q_cmd),
		.cmd_take     (q_take),
		.pop          (pop),
		.empty        (empty),
		.event_kind   (event_kind),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.column       (column),
		.row          (row),
		.last_pixel   (last_pixel),
		.error_code   (error_code),
		.image_width  (image_width),
		.image_height (image_height)
	);

endmodule
